// ===== src/fpt_pkg.sv =====
// Package for the field path tokenizer: grammar phase codes, character
// constants, status codes and the per-item result record.
// No dependencies.
`default_nettype none

package fpt_pkg;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_START      = 3'd0;
  localparam phase_t PH_AFTER_DOT  = 3'd1;
  localparam phase_t PH_IN_NAME    = 3'd2;
  localparam phase_t PH_IDX_FIRST  = 3'd3;
  localparam phase_t PH_IDX_DIGITS = 3'd4;
  localparam phase_t PH_BETWEEN    = 3'd5;
  localparam phase_t PH_SWALLOW    = 3'd6;

  typedef logic [1:0] status_t;

  localparam status_t ST_BUSY   = 2'd0;
  localparam status_t ST_ACCEPT = 2'd1;
  localparam status_t ST_REJECT = 2'd2;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic        name_char_valid;
    logic [7:0]  name_char;
    logic        name_done;
    logic        index_done;
    logic [31:0] index_value;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/fpt_step.sv =====
// Next-state and result logic for one path character of the tokenizer.
// Depends on fpt_pkg.
`default_nettype none

module fpt_step #(
  parameter int INDEX_WIDTH = 32
) (
  input  wire fpt_pkg::phase_t         phase,
  input  wire logic [INDEX_WIDTH-1:0]  accum,
  input  wire logic [7:0]              char_code,
  input  wire logic                    is_end,
  output fpt_pkg::phase_t              phase_nxt,
  output logic [INDEX_WIDTH-1:0]       accum_nxt,
  output fpt_pkg::result_t             res
);
  import fpt_pkg::*;

  localparam int PW = INDEX_WIDTH + 4;
  localparam int VW = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

  logic          is_letter;
  logic          is_digit;
  logic [3:0]    digit;
  logic [PW-1:0] acc_x10;
  logic          ovf;
  logic          reject;
  logic          accept;
  phase_t        ph_step;
  logic [INDEX_WIDTH-1:0] acc_step;

  assign is_letter = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign is_digit  = (char_code inside {[8'h30:8'h39]});
  assign digit     = 4'(char_code - CH_ZERO);
  assign acc_x10   = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0}
                   + {{(PW-4){1'b0}}, digit};
  assign ovf       = |acc_x10[PW-1:INDEX_WIDTH];

  always_comb begin
    res       = '0;
    reject    = 1'b0;
    accept    = 1'b0;
    ph_step   = phase;
    acc_step  = accum;
    case (phase)
      PH_START: begin
        if (is_end) begin
          accept = 1'b1;
        end else if (is_letter) begin
          res.name_char_valid = 1'b1;
          res.name_char       = char_code;
          ph_step             = PH_IN_NAME;
        end else if (char_code == CH_DOT) begin
          ph_step = PH_AFTER_DOT;
        end else if (char_code == CH_LBRK) begin
          ph_step = PH_IDX_FIRST;
        end else begin
          reject = 1'b1;
        end
      end
      PH_AFTER_DOT: begin
        if (!is_end && is_letter) begin
          res.name_char_valid = 1'b1;
          res.name_char       = char_code;
          ph_step             = PH_IN_NAME;
        end else begin
          reject = 1'b1;
        end
      end
      PH_IN_NAME: begin
        if (is_end) begin
          res.name_done = 1'b1;
          accept        = 1'b1;
        end else if (is_letter || is_digit || char_code == CH_UNDER) begin
          res.name_char_valid = 1'b1;
          res.name_char       = char_code;
        end else begin
          res.name_done = 1'b1;
          if (char_code == CH_DOT) begin
            ph_step = PH_AFTER_DOT;
          end else if (char_code == CH_LBRK) begin
            ph_step = PH_IDX_FIRST;
          end else begin
            reject = 1'b1;
          end
        end
      end
      PH_IDX_FIRST: begin
        if (!is_end && is_digit) begin
          acc_step = INDEX_WIDTH'(digit);
          ph_step  = PH_IDX_DIGITS;
        end else begin
          reject = 1'b1;
        end
      end
      PH_IDX_DIGITS: begin
        if (is_end) begin
          reject = 1'b1;
        end else if (is_digit) begin
          if (ovf) begin
            reject = 1'b1;
          end else begin
            acc_step = acc_x10[INDEX_WIDTH-1:0];
          end
        end else if (char_code == CH_RBRK && accum != '0) begin
          res.index_done  = 1'b1;
          res.index_value = 32'(accum[VW-1:0]);
          acc_step        = '0;
          ph_step         = PH_BETWEEN;
        end else begin
          reject = 1'b1;
        end
      end
      PH_BETWEEN: begin
        if (is_end) begin
          accept = 1'b1;
        end else if (char_code == CH_DOT) begin
          ph_step = PH_AFTER_DOT;
        end else if (char_code == CH_LBRK) begin
          ph_step = PH_IDX_FIRST;
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
        res.status = ST_REJECT;
        if (is_end) begin
          ph_step  = PH_START;
          acc_step = '0;
        end
      end
    endcase

    phase_nxt = ph_step;
    accum_nxt = acc_step;
    if (reject) begin
      res.status = ST_REJECT;
      accum_nxt  = '0;
      phase_nxt  = is_end ? PH_START : PH_SWALLOW;
    end else if (accept) begin
      res.status = ST_ACCEPT;
      accum_nxt  = '0;
      phase_nxt  = PH_START;
    end
  end

endmodule

`default_nettype wire

// ===== src/field_path_tokenizer.sv =====
// Field path tokenizer top level: input register, grammar state, result register.
// Depends on fpt_pkg and fpt_step.
//
// Takes a path such as a.b[3].x_ one byte per request, closed by a request with
// in_tlast set, and returns one result per request. A request is held in the
// input register, then its result is written to the output register when the
// output is free; with out_tready held high one request is taken every cycle,
// as the grammar step and multiply-by-ten accumulate are combinational. Results
// show name characters, name and index completion, index values and the accept
// or reject status; after a reject every request up to the end reports reject.
`default_nettype none

module field_path_tokenizer #(
  parameter int INDEX_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] name_char_valid, [8:1] name_char, [9] name_done, [10] index_done,
  // [42:11] index_value, [44:43] status, [47:45] zero
  output logic [fpt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fpt_pkg::*;

  logic                   in_v_r;
  logic [7:0]             in_char_r;
  logic                   in_end_r;
  logic                   out_v_r;
  result_t                res_r;
  phase_t                 phase_r;
  logic [INDEX_WIDTH-1:0] accum_r;

  phase_t                 phase_nxt;
  logic [INDEX_WIDTH-1:0] accum_nxt;
  result_t                res_nxt;
  logic                   advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  fpt_step #(.INDEX_WIDTH(INDEX_WIDTH)) u_step (
    .phase     (phase_r),
    .accum     (accum_r),
    .char_code (in_char_r),
    .is_end    (in_end_r),
    .phase_nxt (phase_nxt),
    .accum_nxt (accum_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_START;
      accum_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, res_r.status, res_r.index_value, res_r.index_done,
                       res_r.name_done, res_r.name_char, res_r.name_char_valid};

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_end_r) |=> (phase_r == PH_START && accum_r == '0))
    else $error("end of path did not return to start");

  a_accum_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDX_DIGITS) |-> (accum_r == '0))
    else $error("index accumulator not clear outside index digits");

  a_reject_swallows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_end_r && res_nxt.status == ST_REJECT) |=> (phase_r == PH_SWALLOW))
    else $error("reject did not enter swallow");

  a_accept_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_nxt.status == ST_ACCEPT) |-> in_end_r)
    else $error("accept without end of path");

endmodule

`default_nettype wire
